/* src/ffd_pkg.sv */
// Shared types and constants for the fixed frame telemetry deframer.
// Used by ffd_front, ffd_queue, ffd_back and the top level; depends on nothing.
package ffd_pkg;

  // Number of decoded fields in one good frame.
  localparam int FIELD_COUNT = 27;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_BYTE    = 3'd0;
  localparam logic [2:0] CFG_TAG_BYTE      = 3'd1;
  localparam logic [2:0] CFG_END_BYTE      = 3'd2;
  localparam logic [2:0] CFG_TAG_WAIT      = 3'd3;
  localparam logic [2:0] CFG_BODY_WAIT     = 3'd4;
  localparam logic [2:0] CFG_DATA_TIMEOUT  = 3'd5;

  // Input item kinds (in_tuser) and result kinds (out_tuser).
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic KIND_FIELD  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Frame hunting phases.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TAG  = 2'd1,
    PH_BODY = 2'd2,
    PH_END  = 2'd3
  } hunt_phase_t;

  // Link status as reported on every result.
  typedef enum logic [1:0] {
    LINK_WAITING   = 2'd0,
    LINK_RECEIVING = 2'd1,
    LINK_TIMEOUT   = 2'd2
  } link_status_t;

  // Field encodings inside the frame body.
  typedef enum logic [1:0] {
    T_U8  = 2'd0,
    T_U16 = 2'd1,
    T_S16 = 2'd2
  } fld_type_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_RD_LO = 2'd1,
    BK_RD_HI = 2'd2,
    BK_EMIT  = 2'd3
  } back_state_t;

  // Body offset of each field's low byte, rpm first and knock last.
  localparam logic [5:0] FLD_POS [FIELD_COUNT] = '{
    6'd4,  6'd6,  6'd8,  6'd9,  6'd11, 6'd13, 6'd15, 6'd17, 6'd19,
    6'd21, 6'd23, 6'd25, 6'd27, 6'd29, 6'd31, 6'd33, 6'd35, 6'd37,
    6'd39, 6'd41, 6'd43, 6'd45, 6'd47, 6'd48, 6'd49, 6'd53, 6'd55
  };

  localparam fld_type_t FLD_TYPE [FIELD_COUNT] = '{
    T_S16, T_U16, T_U8,  T_U16, T_U16, T_U16,
    T_S16, T_S16, T_S16, T_S16, T_S16, T_S16, T_S16, T_S16,
    T_U16, T_S16, T_S16, T_S16, T_S16, T_S16, T_S16,
    T_U16, T_U8,  T_U8,  T_U16, T_U16, T_U16
  };

  // One piece of work handed from the front to the back part.
  typedef struct packed {
    logic         is_status;
    logic [31:0]  frame_total;
    link_status_t link_status;
    logic         became_active;
  } q_entry_t;

  // Body byte write from the front into the back part's payload memory.
  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [7:0] data;
  } mem_wr_t;

endpackage

/* src/ffd_front.sv */
// Front part of the deframer: configuration registers, frame hunting, timers
// and link status. Depends on ffd_pkg; feeds ffd_queue and the payload memory.
module ffd_front #(
  parameter int PAYLOAD_BYTES = 93
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_action,
  input  logic [7:0]        in_byte,
  // Configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  // Toward the queue and the back part
  output logic              q_push,
  output ffd_pkg::q_entry_t q_entry,
  input  logic              q_full,
  input  logic              emit_busy,
  output ffd_pkg::mem_wr_t  mem_wr
);
  import ffd_pkg::*;

  localparam int BODY_BYTES = PAYLOAD_BYTES - 1;

  logic [7:0]   start_byte_r, tag_byte_r, end_byte_r, tag_wait_r;
  logic [9:0]   body_wait_r;
  logic [15:0]  data_timeout_r;

  hunt_phase_t  phase_r, phase_nxt;
  logic [6:0]   pos_r, pos_nxt;
  logic [9:0]   wait_r, wait_nxt;
  link_status_t link_r, link_nxt;
  logic [15:0]  idle_r, idle_nxt;
  logic         seen_r, seen_nxt;
  logic [31:0]  frames_r, frames_nxt;

  logic         accept;
  logic [9:0]   wait_inc;
  logic [9:0]   wait_lim;
  logic         wait_expired;
  logic         timeout_hit;
  logic         body_last;

  // Body bytes hold off while a frame is still being read out of the memory.
  assign in_tready = !q_full && !(phase_r == PH_BODY && emit_busy);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign wait_inc     = wait_r + 10'd1;
  assign wait_lim     = (phase_r == PH_TAG) ? {2'b00, tag_wait_r} : body_wait_r;
  assign wait_expired = (wait_inc >= wait_lim);
  assign timeout_hit  = (link_r == LINK_RECEIVING) && seen_r && (idle_r >= data_timeout_r);
  assign body_last    = (pos_r == 7'(BODY_BYTES - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= 8'd2;
      tag_byte_r     <= 8'd95;
      end_byte_r     <= 8'd3;
      tag_wait_r     <= 8'd50;
      body_wait_r    <= 10'd200;
      data_timeout_r <= 16'd3000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_BYTE:   start_byte_r   <= cfg_data[7:0];
        CFG_TAG_BYTE:     tag_byte_r     <= cfg_data[7:0];
        CFG_END_BYTE:     end_byte_r     <= cfg_data[7:0];
        CFG_TAG_WAIT:     tag_wait_r     <= cfg_data[7:0];
        CFG_BODY_WAIT:    body_wait_r    <= cfg_data[9:0];
        CFG_DATA_TIMEOUT: data_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next hunting phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_action == ACT_TICK) begin
        if (phase_r != PH_HUNT && wait_expired) begin
          phase_nxt = PH_HUNT;
        end
      end else begin
        case (phase_r)
          PH_HUNT: if (in_byte == start_byte_r) phase_nxt = PH_TAG;
          PH_TAG:  phase_nxt = (in_byte == tag_byte_r) ? PH_BODY : PH_HUNT;
          PH_BODY: if (body_last) phase_nxt = PH_END;
          PH_END:  phase_nxt = PH_HUNT;
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  // Counters, link status, queue pushes and memory writes.
  always_comb begin
    pos_nxt    = pos_r;
    wait_nxt   = wait_r;
    link_nxt   = link_r;
    idle_nxt   = idle_r;
    seen_nxt   = seen_r;
    frames_nxt = frames_r;
    q_push     = 1'b0;
    q_entry    = '{is_status: 1'b0, frame_total: frames_r,
                   link_status: link_r, became_active: 1'b0};
    mem_wr     = '{en: 1'b0, addr: pos_r, data: in_byte};
    if (accept) begin
      if (in_action == ACT_TICK) begin
        if (phase_r != PH_HUNT) begin
          wait_nxt = wait_expired ? 10'd0 : wait_inc;
        end
        if (timeout_hit) begin
          link_nxt = LINK_TIMEOUT;
          q_push   = 1'b1;
          q_entry  = '{is_status: 1'b1, frame_total: frames_r,
                       link_status: LINK_TIMEOUT, became_active: 1'b0};
        end
        if (idle_r != 16'hFFFF) begin
          idle_nxt = idle_r + 16'd1;
        end
      end else begin
        case (phase_r)
          PH_HUNT: if (in_byte == start_byte_r) wait_nxt = 10'd0;
          PH_TAG: begin
            if (in_byte == tag_byte_r) begin
              pos_nxt  = 7'd0;
              wait_nxt = 10'd0;
            end
          end
          PH_BODY: begin
            mem_wr.en = 1'b1;
            pos_nxt   = pos_r + 7'd1;
          end
          PH_END: begin
            wait_nxt = 10'd0;
            if (in_byte == end_byte_r) begin
              frames_nxt = frames_r + 32'd1;
              link_nxt   = LINK_RECEIVING;
              seen_nxt   = 1'b1;
              idle_nxt   = 16'd0;
              q_push     = 1'b1;
              q_entry    = '{is_status: 1'b0, frame_total: frames_r + 32'd1,
                             link_status: LINK_RECEIVING,
                             became_active: (link_r != LINK_RECEIVING)};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      pos_r    <= 7'd0;
      wait_r   <= 10'd0;
      link_r   <= LINK_WAITING;
      idle_r   <= 16'd0;
      seen_r   <= 1'b0;
      frames_r <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      wait_r   <= wait_nxt;
      link_r   <= link_nxt;
      idle_r   <= idle_nxt;
      seen_r   <= seen_nxt;
      frames_r <= frames_nxt;
    end
  end

endmodule

/* src/ffd_queue.sv */
// Short queue of work entries between the front and back parts.
// Depends on ffd_pkg for the entry type and depth.
module ffd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ffd_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output ffd_pkg::q_entry_t head
);
  import ffd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        slots_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/ffd_back.sv */
// Back part of the deframer: payload memory, field readout sequencer and the
// output register. Depends on ffd_pkg; fed by ffd_queue and ffd_front.
module ffd_back #(
  parameter int PAYLOAD_BYTES = 93
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffd_pkg::mem_wr_t     mem_wr,
  input  logic                 q_valid,
  input  ffd_pkg::q_entry_t    q_head,
  output logic                 q_pop,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [4:0]           out_field_id,
  output logic signed [16:0]   out_field_value,
  output logic                 out_last,
  output logic [31:0]          out_frame_total,
  output ffd_pkg::link_status_t out_link_status,
  output logic                 out_became_active
);
  import ffd_pkg::*;

  localparam int BODY_BYTES = PAYLOAD_BYTES - 1;
  localparam int AW         = $clog2(BODY_BYTES);

  logic [7:0]         mem [BODY_BYTES];
  logic [7:0]         rd_data_r;
  logic [AW-1:0]      rd_addr;

  back_state_t        state_r, state_nxt;
  q_entry_t           cur_r;
  logic [4:0]         k_r;
  logic [7:0]         lo_r;
  logic               out_load;
  logic               last_item;
  fld_type_t          ftype;
  logic signed [16:0] fvalue;

  logic               ov_r;
  logic               o_kind_r, o_last_r, o_became_r;
  logic [4:0]         o_id_r;
  logic signed [16:0] o_value_r;
  logic [31:0]        o_total_r;
  link_status_t       o_link_r;

  // Payload memory: one write port from the front, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Low byte address while fetching it, high byte address afterwards.
  assign rd_addr = (state_r == BK_RD_LO) ? AW'(FLD_POS[k_r])
                                         : AW'(FLD_POS[k_r]) + AW'(1);

  assign out_load  = (state_r == BK_EMIT) && (!ov_r || out_ready);
  assign last_item = cur_r.is_status || (k_r == 5'(FIELD_COUNT - 1));
  assign q_pop     = (state_r == BK_IDLE) && q_valid;
  assign busy      = (state_r != BK_IDLE);
  assign ftype     = FLD_TYPE[k_r];

  // Field value from the field's low byte and, for 16-bit types, its high byte.
  always_comb begin
    case (ftype)
      T_U8:    fvalue = {9'd0, lo_r};
      T_U16:   fvalue = {1'b0, rd_data_r, lo_r};
      T_S16:   fvalue = {rd_data_r[7], rd_data_r, lo_r};
      default: fvalue = '0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) state_nxt = q_head.is_status ? BK_EMIT : BK_RD_LO;
      end
      BK_RD_LO: state_nxt = BK_RD_HI;
      BK_RD_HI: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_load) state_nxt = last_item ? BK_IDLE : BK_RD_LO;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Work entry, field index and low byte capture.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
      k_r   <= 5'd0;
    end else if (out_load && !last_item) begin
      k_r <= k_r + 5'd1;
    end
    if (state_r == BK_RD_HI) begin
      lo_r <= rd_data_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind_r   <= cur_r.is_status ? KIND_STATUS : KIND_FIELD;
      o_id_r     <= cur_r.is_status ? 5'd0 : k_r;
      o_value_r  <= cur_r.is_status ? 17'sd0 : fvalue;
      o_last_r   <= last_item;
      o_total_r  <= cur_r.frame_total;
      o_link_r   <= cur_r.link_status;
      o_became_r <= cur_r.became_active;
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = o_kind_r;
  assign out_field_id      = o_id_r;
  assign out_field_value   = o_value_r;
  assign out_last          = o_last_r;
  assign out_frame_total   = o_total_r;
  assign out_link_status   = o_link_r;
  assign out_became_active = o_became_r;

endmodule

/* src/fixed_frame_telemetry_deframer_unit.sv */
// Fixed frame telemetry deframer, top level.
// Joins ffd_front, ffd_queue and ffd_back; depends on ffd_pkg.
//
// Usage:
//   The in_ channel carries one item per transfer: in_tuser is 0 for a
//   received byte (in in_tdata) and 1 for a one millisecond tick. The block
//   hunts for start, tag, a fixed body and end byte and, for every good frame,
//   sends 27 field results on the out_ channel, the last one with out_tlast.
//   A data timeout sends one status result (out_tuser 1, out_tlast 1).
//   The cfg_ channel writes the six registers; it is always ready. The user must
//   see that it is written only while the block is idle; the block does not enforce it.
// Timing:
//   Ticks and bytes outside a frame body are taken one per cycle while the
//   queue is not full. Each field passes through the readout sequencer's low
//   byte read, high byte read and output load states on the single memory
//   read port. Body bytes of the next frame wait while a burst is read out.
// Reset: rst_n, synchronous, clears control state and loads register
//   defaults; the payload memory is not cleared. A stalled receiver holds the
//   output register and backs up the queue, which then stalls the input.
module fixed_frame_telemetry_deframer_unit #(
  parameter int PAYLOAD_BYTES = 93
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] action
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [4:0] field_id, [21:5] field_value,
                                  // [53:22] frame_total, [55:54] link_status,
                                  // [56] became_active, [63:57] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,  // last_field
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ffd_pkg::*;

  logic               q_push, q_full, q_pop, q_valid, back_busy, emit_busy;
  q_entry_t           q_entry, q_head;
  mem_wr_t            mem_wr;
  logic [4:0]         field_id;
  logic signed [16:0] field_value;
  logic [31:0]        frame_total;
  link_status_t       link_status;
  logic               became_active;

  // A frame is still pending while the queue or the readout holds work.
  assign emit_busy = q_valid || back_busy;

  ffd_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_byte   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full),
    .emit_busy (emit_busy),
    .mem_wr    (mem_wr)
  );

  ffd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  ffd_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_wr            (mem_wr),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .busy              (back_busy),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_kind          (out_tuser),
    .out_field_id      (field_id),
    .out_field_value   (field_value),
    .out_last          (out_tlast),
    .out_frame_total   (frame_total),
    .out_link_status   (link_status),
    .out_became_active (became_active)
  );

  // Result payload packing, lowest field first.
  assign out_tdata = {7'd0, became_active, link_status, frame_total,
                      field_value, field_id};

endmodule
